// File: src/kpe_pkg.sv
// Shared types and constants for the k-permutation enumerator.
// No dependencies; every other file of the block imports this package.
package kpe_pkg;

  // Default sizes of the element store and of one selection.
  localparam int MAX_SET_DEF  = 16;
  localparam int MAX_PICK_DEF = 8;
  localparam int DATA_W       = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 2'd1;
  localparam int CFG_DATA_W = 5;

  // Input word kinds.
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic [3:0]               position;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]               slot;
    logic signed [DATA_W-1:0] element;
    logic                     last;
    logic                     exhausted;
  } out_word_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE, S_ORDER, S_CBEGIN, S_COMB, S_PINIT, S_PERM, S_READ, S_WRITE
  } ctrl_state_t;

  // Extra state for the exhausted answer is folded into a separate flag.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RESTART, OP_START, OP_FINISH, OP_ORD_BEGIN, OP_ORD_STEP,
    OP_COMB_BEGIN, OP_COMB_STEP, OP_PERM_BEGIN, OP_PERM_STEP, OP_EMIT_RD,
    OP_EMIT_WR, OP_EXH_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic finished;
    logic empty;
    logic k_small;
    logic ord_ok;
    logic comb_ok;
    logic idx_zero;
    logic perm_done;
    logic slot_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: src/kpe_dp.sv
// Datapath of the k-permutation enumerator: store, level counters, output register.
// Depends on kpe_pkg; driven by kpe_ctrl through a command word.
module kpe_dp #(
  parameter int MAX_SET  = kpe_pkg::MAX_SET_DEF,
  parameter int MAX_PICK = kpe_pkg::MAX_PICK_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kpe_pkg::in_word_t                in_data,
  input  logic                             cfg_valid,
  input  logic [kpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kpe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  kpe_pkg::dp_cmd_t                 cmd,
  output kpe_pkg::dp_status_t              status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output kpe_pkg::out_word_t               out_data
);
  import kpe_pkg::*;

  localparam int SW  = $clog2(MAX_SET);
  localparam int KW  = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int NCW = $clog2(MAX_SET + 1);
  localparam int KCW = $clog2(MAX_PICK + 1);
  localparam int CW  = NCW + KW + 2;

  logic [4:0]        set_size;
  logic [3:0]        pick_count;
  logic              started;
  logic              finished;
  logic [SW-1:0]     chosen [MAX_PICK];
  logic [KW-1:0]     swapc  [MAX_PICK];
  logic [KW-1:0]     perm   [MAX_PICK];
  logic [KW-1:0]     idx;
  logic [KW-1:0]     slot_cnt;
  logic [DATA_W-1:0] store  [MAX_SET];
  logic [DATA_W-1:0] rdata;
  out_word_t         out_reg;

  logic [NCW-1:0] n_eff;
  logic [KCW-1:0] k_eff;
  logic [KW-1:0]  partner;
  logic [SW-1:0]  rd_addr;
  logic           out_free;

  // Effective sizes, clamped to the built store and selection depth.
  always_comb begin
    n_eff = (int'(set_size) > MAX_SET) ? NCW'(MAX_SET) : NCW'(set_size);
    k_eff = (int'(pick_count) > MAX_PICK) ? KCW'(MAX_PICK) : KCW'(pick_count);
  end

  assign partner  = swapc[idx];
  assign rd_addr  = chosen[perm[slot_cnt]];
  assign out_free = !out_valid || out_ready;

  // Status toward the controller.
  always_comb begin
    status.started   = started;
    status.finished  = finished;
    status.empty     = (k_eff == '0) || (int'(k_eff) > int'(n_eff));
    status.k_small   = int'(k_eff) < 2;
    status.ord_ok    = int'(swapc[idx]) < int'(k_eff) - 1;
    status.comb_ok   = (CW'(chosen[idx]) + CW'(k_eff)) < (CW'(n_eff) + CW'(idx));
    status.idx_zero  = (idx == '0);
    status.perm_done = int'(idx) + 1 >= int'(k_eff);
    status.slot_last = int'(slot_cnt) + 1 == int'(k_eff);
    status.out_free  = out_free;
  end

  // Element store with registered read.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && int'(in_data.position) < MAX_SET) begin
      store[SW'(in_data.position)] <= in_data.value;
    end
    if (cmd.op == OP_EMIT_RD) begin
      rdata <= store[rd_addr];
    end
  end

  // Enumeration state, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_size   <= 5'd4;
      pick_count <= 4'd3;
      started    <= 1'b0;
      finished   <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      slot_cnt   <= '0;
      for (int j = 0; j < MAX_PICK; j++) begin
        chosen[j] <= '0;
        swapc[j]  <= '0;
      end
    end else begin
      // A word leaving clears the register unless a new word is written in the same cycle.
      if (out_valid && out_ready && cmd.op != OP_EMIT_WR && cmd.op != OP_EXH_WR) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && (cfg_index == REG_SET_SIZE || cfg_index == REG_PICK_COUNT)) begin
        if (cfg_index == REG_SET_SIZE) begin
          set_size <= cfg_data;
        end else begin
          pick_count <= cfg_data[3:0];
        end
        started  <= 1'b0;
        finished <= 1'b0;
        for (int j = 0; j < MAX_PICK; j++) begin
          chosen[j] <= '0;
          swapc[j]  <= '0;
        end
      end
      case (cmd.op)
        OP_RESTART: begin
          started  <= 1'b0;
          finished <= 1'b0;
          for (int j = 0; j < MAX_PICK; j++) begin
            chosen[j] <= '0;
            swapc[j]  <= '0;
          end
        end
        OP_START: begin
          started <= 1'b1;
          for (int j = 0; j < MAX_PICK; j++) begin
            chosen[j] <= SW'(j);
            swapc[j]  <= KW'(j);
          end
        end
        OP_FINISH: finished <= 1'b1;
        OP_ORD_BEGIN: idx <= KW'(int'(k_eff) - 2);
        OP_ORD_STEP: begin
          // One level of the swap counters per cycle, deepest first.
          if (status.ord_ok) begin
            swapc[idx] <= swapc[idx] + 1'b1;
          end else begin
            swapc[idx] <= idx;
            if (idx != '0) idx <= idx - 1'b1;
          end
        end
        OP_COMB_BEGIN: idx <= KW'(int'(k_eff) - 1);
        OP_COMB_STEP: begin
          // Scan positions from the right for one that can still advance.
          if (status.comb_ok) begin
            for (int j = 0; j < MAX_PICK; j++) begin
              if (j >= int'(idx)) begin
                chosen[j] <= SW'(int'(chosen[idx]) + 1 + j - int'(idx));
              end
              swapc[j] <= KW'(j);
            end
          end else if (idx == '0) begin
            finished <= 1'b1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        OP_PERM_BEGIN: begin
          idx      <= '0;
          slot_cnt <= '0;
          for (int j = 0; j < MAX_PICK; j++) begin
            perm[j] <= KW'(j);
          end
        end
        OP_PERM_STEP: begin
          // A level whose partner is itself leaves the order as it is.
          if (partner != idx) begin
            perm[idx]     <= perm[partner];
            perm[partner] <= perm[idx];
          end
          idx <= idx + 1'b1;
        end
        OP_EMIT_WR: begin
          out_reg.slot      <= 3'(slot_cnt);
          out_reg.element   <= rdata;
          out_reg.last      <= status.slot_last;
          out_reg.exhausted <= 1'b0;
          out_valid         <= 1'b1;
          slot_cnt          <= slot_cnt + 1'b1;
        end
        OP_EXH_WR: begin
          out_reg.slot      <= 3'd0;
          out_reg.element   <= '0;
          out_reg.last      <= 1'b1;
          out_reg.exhausted <= 1'b1;
          out_valid         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_data = out_reg;

  // An exhausted answer always stands alone with a zero element.
  a_exh_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.exhausted |-> out_reg.last && out_reg.element == '0)
    else $error("exhausted word malformed");

  // The controller only writes the output register when it is free.
  a_wr_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT_WR || cmd.op == OP_EXH_WR |-> out_free)
    else $error("output register overwritten");

  // A swap partner never lies left of its level.
  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PERM_STEP |-> partner >= idx)
    else $error("swap counter below its level");

endmodule

// File: src/kpe_ctrl.sv
// Controller state machine of the k-permutation enumerator.
// Depends on kpe_pkg; sequences kpe_dp through command and status words.
module kpe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  kpe_pkg::dp_status_t status,
  output kpe_pkg::dp_cmd_t    cmd
);
  import kpe_pkg::*;

  ctrl_state_t state, state_next;
  logic        exh, exh_next;

  // State register; exh marks a pending exhausted answer in the write state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      exh   <= 1'b0;
    end else begin
      state <= state_next;
      exh   <= exh_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    exh_next   = exh;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_kind == KIND_REQUEST) begin
          if (status.finished || (!status.started && status.empty)) begin
            state_next = S_WRITE;
            exh_next   = 1'b1;
          end else if (!status.started) begin
            state_next = S_PINIT;
          end else if (status.k_small) begin
            state_next = S_CBEGIN;
          end else begin
            state_next = S_ORDER;
          end
        end
      end
      S_ORDER: begin
        if (status.ord_ok) state_next = S_PINIT;
        else if (status.idx_zero) state_next = S_CBEGIN;
      end
      S_CBEGIN: state_next = S_COMB;
      S_COMB: begin
        if (status.comb_ok) begin
          state_next = S_PINIT;
        end else if (status.idx_zero) begin
          state_next = S_WRITE;
          exh_next   = 1'b1;
        end
      end
      S_PINIT: state_next = S_PERM;
      S_PERM: begin
        if (status.perm_done) state_next = S_WRITE;
      end
      S_READ: state_next = S_WRITE;
      S_WRITE: begin
        if (status.out_free) begin
          if (exh || status.slot_last) begin
            state_next = S_IDLE;
            exh_next   = 1'b0;
          end else begin
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: one datapath command per cycle.
  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.op   = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.op = OP_LOAD;
          end else if (in_kind == KIND_RESTART) begin
            cmd.op = OP_RESTART;
          end else if (in_kind == KIND_REQUEST && !status.finished) begin
            if (!status.started) cmd.op = status.empty ? OP_FINISH : OP_START;
            else if (status.k_small) cmd.op = OP_NONE;
            else cmd.op = OP_ORD_BEGIN;
          end
        end
      end
      S_ORDER:  cmd.op = OP_ORD_STEP;
      S_CBEGIN: cmd.op = OP_COMB_BEGIN;
      S_COMB:   cmd.op = OP_COMB_STEP;
      S_PINIT:  cmd.op = OP_PERM_BEGIN;
      S_PERM:   cmd.op = status.perm_done ? OP_EMIT_RD : OP_PERM_STEP;
      S_READ:   cmd.op = OP_EMIT_RD;
      S_WRITE: begin
        if (status.out_free) cmd.op = exh ? OP_EXH_WR : OP_EMIT_WR;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: src/k_permutation_enumerator.sv
// A request steps the swap-counter levels (S_ORDER, one per cycle) or, once they are spent, the
// combination positions (S_CBEGIN, S_COMB), then applies the k-1 swaps (S_PINIT, S_PERM).
// Input words are taken only in S_IDLE, so a request completes before the next word is taken.
// The store has one read port; each selection word is read, then written out in S_WRITE.
// Synchronous active-high reset: set_size 4, pick_count 3, enumeration restarted, store undefined.
// Top level of the k-permutation enumerator; depends on kpe_pkg, kpe_ctrl and kpe_dp.
module k_permutation_enumerator #(
  parameter int MAX_SET  = kpe_pkg::MAX_SET_DEF,
  parameter int MAX_PICK = kpe_pkg::MAX_PICK_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kpe_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kpe_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kpe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Register writes are taken while the controller is idle and no input word is offered.
  assign cfg_ready = in_ready && !in_valid;

  kpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_data.kind),
    .status   (status),
    .cmd      (cmd)
  );

  kpe_dp #(
    .MAX_SET  (MAX_SET),
    .MAX_PICK (MAX_PICK)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: dv/tb_k_permutation_enumerator.sv
// Self-checking testbench for k_permutation_enumerator: random words with
// random gaps and stalls, checked against a selection predictor in a small class.
// Depends on kpe_pkg and the RTL of the block only.
module tb_k_permutation_enumerator;
  timeunit 1ns;
  timeprecision 1ps;
  import kpe_pkg::*;

  // Predicts the selection words of the block and checks the words that arrive.
  class selection_scoreboard;
    logic signed [DATA_W-1:0] store_q [MAX_SET_DEF];
    logic [3:0] chosen [MAX_PICK_DEF];
    logic [3:0] swaps [MAX_PICK_DEF];
    bit started, finished;
    logic [4:0] set_size;
    logic [3:0] pick_count;
    out_word_t expected_q [$];
    int errors;

    function void reset_state();
      set_size = 5'd4;
      pick_count = 4'd3;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < MAX_PICK_DEF; i++) begin
        chosen[i] = '0;
        swaps[i] = '0;
      end
      started = 0;
      finished = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SET_SIZE) begin
        set_size = data;
      end else if (idx == REG_PICK_COUNT) begin
        pick_count = data[3:0];
      end else begin
        return;
      end
      restart();
    endfunction

    function void push_exhausted();
      out_word_t w;
      w.slot = '0;
      w.element = '0;
      w.last = 1'b1;
      w.exhausted = 1'b1;
      expected_q.push_back(w);
      finished = 1;
    endfunction

    // Reads the chosen slots, applies the swaps level by level and queues the words.
    function void push_selection(int k);
      logic signed [DATA_W-1:0] arr [MAX_PICK_DEF];
      logic signed [DATA_W-1:0] t;
      out_word_t w;
      for (int i = 0; i < k; i++) arr[i] = store_q[chosen[i]];
      for (int i = 0; i + 1 < k; i++) begin
        t = arr[i];
        arr[i] = arr[swaps[i] % MAX_PICK_DEF];
        arr[swaps[i] % MAX_PICK_DEF] = t;
      end
      for (int i = 0; i < k; i++) begin
        w.slot = i[2:0];
        w.element = arr[i];
        w.last = (i + 1 == k);
        w.exhausted = 1'b0;
        expected_q.push_back(w);
      end
    endfunction

    // Notes one accepted input word and queues the words it should cause.
    function void note_input(in_word_t w);
      int n, k, d, p;
      bit stepped;
      n = (set_size > MAX_SET_DEF) ? MAX_SET_DEF : set_size;
      k = (pick_count > MAX_PICK_DEF) ? MAX_PICK_DEF : pick_count;
      if (w.kind == KIND_LOAD) begin
        store_q[w.position] = w.value;
        return;
      end
      if (w.kind == KIND_RESTART) begin
        restart();
        return;
      end
      if (w.kind != KIND_REQUEST) return;
      if (finished) begin
        push_exhausted();
        return;
      end
      if (!started) begin
        if (k == 0 || k > n) begin
          push_exhausted();
          return;
        end
        for (int i = 0; i < k; i++) begin
          chosen[i] = i;
          swaps[i] = i;
        end
        started = 1;
        push_selection(k);
        return;
      end
      // Advance the swap counters, deepest level first.
      stepped = 0;
      d = (k > 1) ? k - 1 : 0;
      while (d > 0 && !stepped) begin
        swaps[d-1]++;
        if (swaps[d-1] <= k - 1) begin
          stepped = 1;
        end else begin
          swaps[d-1] = d - 1;
          d--;
        end
      end
      // Otherwise move to the next combination in lexicographic order.
      if (!stepped) begin
        p = k - 1;
        while (p >= 0 && !stepped) begin
          if (chosen[p] < n - k + p) begin
            chosen[p]++;
            for (int j = p + 1; j < k; j++) chosen[j] = chosen[j-1] + 1;
            for (int j = 0; j < k; j++) swaps[j] = j;
            stepped = 1;
          end
          p--;
        end
      end
      if (stepped) push_selection(k);
      else push_exhausted();
    endfunction

    // Compares one accepted output word with the oldest expectation.
    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word slot=%0d element=%0d last=%0b exhausted=%0b",
                 $time, got.slot, got.element, got.last, got.exhausted);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.slot !== exp_w.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, exp_w.slot, got.slot);
        errors++;
      end
      if (got.element !== exp_w.element) begin
        $display("%0t: element expected %0d actual %0d", $time, exp_w.element, got.element);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_w.last, got.last);
        errors++;
      end
      if (got.exhausted !== exp_w.exhausted) begin
        $display("%0t: exhausted expected %0b actual %0b", $time, exp_w.exhausted,
                 got.exhausted);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 80;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_word_t in_data;
  out_word_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  selection_scoreboard sb;
  bit quiet;
  int stall_left;
  int idle_cycles;

  k_permutation_enumerator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in quiet phases.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Check every output word accepted at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one input word; called and returning at a falling edge.
  task automatic send_word(in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_kind(logic [1:0] kind, logic [3:0] position, logic signed [31:0] value);
    in_word_t w;
    w.kind = kind;
    w.position = position;
    w.value = value;
    send_word(w);
  endtask

  // Lets all expected words drain, then the block settle, with the input idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random mix: mostly requests, with loads, restarts and unused kinds between.
  task automatic random_phase(int count);
    int r;
    logic [1:0] kind;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 72) kind = KIND_REQUEST;
      else if (r < 88) kind = KIND_LOAD;
      else if (r < 95) kind = KIND_RESTART;
      else kind = 2'd3;
      send_kind(kind, 4'($urandom_range(0, 15)), $urandom);
    end
  endtask

  initial begin
    logic signed [31:0] extremes [4];
    int sizes [10];
    int picks [10];
    sb = new();
    sb.errors = 0;
    quiet = 0;
    stall_left = 0;
    idle_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sb.reset_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every slot, extremes first, so no unwritten slot is ever read.
    extremes = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};
    for (int i = 0; i < 16; i++)
      send_kind(KIND_LOAD, 4'(i), (i < 4) ? extremes[i] : $urandom);
    // Default registers, an unused kind, a restart and a reload during enumeration.
    send_kind(KIND_REQUEST, '0, '0);
    send_kind(2'd3, 4'hF, -32'sd1);
    send_kind(KIND_REQUEST, '0, '0);
    send_kind(KIND_RESTART, '0, '0);
    send_kind(KIND_REQUEST, '0, '0);
    send_kind(KIND_LOAD, 4'd1, 32'sh1234_5678);
    send_kind(KIND_REQUEST, '0, '0);
    send_kind(KIND_REQUEST, '0, '0);
    wait_idle();

    // Register settings: extremes, empty sets, oversized values, then random ones.
    sizes = '{1, 16, 16, 0, 31, 5, 3, 16, 4, 2};
    picks = '{1, 8, 15, 3, 1, 6, 3, 16, 2, 2};
    for (int ph = 0; ph < 14; ph++) begin
      quiet = (ph % 4 == 3);
      if (ph < 10) begin
        write_reg(REG_SET_SIZE, 5'(sizes[ph]));
        write_reg(REG_PICK_COUNT, 5'(picks[ph]));
      end else begin
        write_reg(REG_PICK_COUNT, 5'($urandom_range(0, 31)));
        write_reg(REG_SET_SIZE, 5'($urandom_range(0, 31)));
      end
      random_phase(30);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
